FILE: hdl/zfci_pkg.sv
// zfci_pkg: shared constants, curve tables and stage records for the
// zoom/focus curve interpolator. No dependencies.
package zfci_pkg;

  // field widths and curve size
  localparam int CURVE_POINTS = 14;
  localparam int SEGS         = CURVE_POINTS - 1;
  localparam int ZOOM_W       = 12;
  localparam int FOCUS_W      = 13;
  localparam int FOCUS_MAX    = 8191;

  // index widths
  localparam int IDX_W = $clog2(CURVE_POINTS + 1);
  localparam int PT_W  = $clog2(CURVE_POINTS);
  localparam int SEG_W = (SEGS > 1) ? $clog2(SEGS) : 1;

  // product and reciprocal widths; quotient = (p * rcp) >> RCP_SH
  localparam int P_W    = ZOOM_W + FOCUS_W;
  localparam int RCP_SH = P_W;
  localparam int RCP_W  = P_W + 1;

  // register stages from input request to result
  localparam int PIPE_DEPTH = 6;

  // breakpoints of the curve
  localparam logic [ZOOM_W-1:0] ZOOM_ROM [CURVE_POINTS] = '{
    12'd20,   12'd50,   12'd90,   12'd180,  12'd373,  12'd565,  12'd758,
    12'd950,  12'd1143, 12'd1335, 12'd1528, 12'd1720, 12'd1913, 12'd2106
  };

  localparam logic [FOCUS_W-1:0] FOCUS_ROM [CURVE_POINTS] = '{
    13'd0,    13'd205,  13'd208,  13'd219,  13'd244,  13'd291,  13'd350,
    13'd438,  13'd574,  13'd703,  13'd902,  13'd1158, 13'd1505, 13'd1983
  };

  // ceil(2^RCP_SH / zoom span) for each segment
  localparam logic [RCP_W-1:0] RCP_ROM [SEGS] = '{
    26'd1118482, 26'd838861, 26'd372828, 26'd173858, 26'd174763,
    26'd173858,  26'd174763, 26'd173858, 26'd174763, 26'd173858,
    26'd174763,  26'd173858, 26'd173858
  };

  // segment record after the search stages
  typedef struct packed {
    logic               valid;
    logic [ZOOM_W-1:0]  off;
    logic [FOCUS_W-1:0] df;
    logic [ZOOM_W-1:0]  dz;
    logic [RCP_W-1:0]   rcp;
    logic [FOCUS_W-1:0] f0;
    logic               hold;
  } zfci_seg_t;

  // quotient record after the divide stages
  typedef struct packed {
    logic               valid;
    logic [FOCUS_W-1:0] f0;
    logic [P_W-1:0]     q;
  } zfci_quo_t;

endpackage

FILE: hdl/zfci_if.sv
// zfci_if: valid/ready channel interfaces for the zoom input and the focus result.
// Depends on zfci_pkg.
interface zfci_in_if import zfci_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ZOOM_W-1:0] zoom_step;

  modport source (output valid, output zoom_step, input ready);
  modport sink   (input valid, input zoom_step, output ready);
  modport mon    (input valid, input zoom_step, input ready);
endinterface

interface zfci_out_if import zfci_pkg::*;;
  logic               valid;
  logic               ready;
  logic [FOCUS_W-1:0] focus_step;

  modport source (output valid, output focus_step, input ready);
  modport sink   (input valid, input focus_step, output ready);
  modport mon    (input valid, input focus_step, input ready);
endinterface

FILE: hdl/zfci_search.sv
// zfci_search: breakpoint search (stage 1) and segment table fetch (stage 2).
// Depends on zfci_pkg.
module zfci_search import zfci_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [ZOOM_W-1:0] zoom_step,
  output zfci_seg_t         seg
);

  logic              v1_r;
  logic [IDX_W-1:0]  idx1_r;
  logic [IDX_W-1:0]  idx_nxt;
  logic [ZOOM_W-1:0] z1_r;
  logic [PT_W-1:0]   lo;
  logic [PT_W-1:0]   hi;
  logic [PT_W-1:0]   base;
  logic              below;
  zfci_seg_t         seg_r;
  zfci_seg_t         seg_nxt;

  // first breakpoint strictly above the input
  always_comb begin
    idx_nxt = IDX_W'(CURVE_POINTS);
    for (int i = CURVE_POINTS - 1; i >= 0; i--) begin
      if (zoom_step < ZOOM_ROM[i]) begin
        idx_nxt = IDX_W'(i);
      end
    end
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1_r <= idx_nxt;
      z1_r   <= zoom_step;
    end
  end

  // segment ends and base point
  always_comb begin
    below = 1'b0;
    if (idx1_r == IDX_W'(CURVE_POINTS)) begin
      lo   = PT_W'(CURVE_POINTS - 2);
      hi   = PT_W'(CURVE_POINTS - 1);
      base = PT_W'(CURVE_POINTS - 1);
    end else if (idx1_r == '0) begin
      below = 1'b1;
      lo    = '0;
      hi    = PT_W'(1);
      base  = '0;
    end else begin
      lo   = PT_W'(idx1_r - IDX_W'(1));
      hi   = PT_W'(idx1_r);
      base = PT_W'(idx1_r - IDX_W'(1));
    end
  end

  // segment fetch
  always_comb begin
    seg_nxt.valid = v1_r;
    seg_nxt.off   = z1_r - ZOOM_ROM[base];
    seg_nxt.df    = FOCUS_ROM[hi] - FOCUS_ROM[lo];
    seg_nxt.dz    = ZOOM_ROM[hi] - ZOOM_ROM[lo];
    seg_nxt.rcp   = RCP_ROM[SEG_W'(lo)];
    seg_nxt.f0    = FOCUS_ROM[base];
    seg_nxt.hold  = below || (ZOOM_ROM[hi] <= ZOOM_ROM[lo]) ||
                    (FOCUS_ROM[hi] < FOCUS_ROM[lo]);
  end

  // stage 2 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r.valid <= 1'b0;
    end else if (en) begin
      seg_r <= seg_nxt;
    end
  end

  assign seg = seg_r;

endmodule

FILE: hdl/zfci_divide.sv
// zfci_divide: offset times focus span, reciprocal divide by zoom span, and
// one-step quotient correction (stages 3 to 5). Depends on zfci_pkg.
module zfci_divide import zfci_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  zfci_seg_t seg,
  output zfci_quo_t quo
);

  typedef struct packed {
    logic               valid;
    logic [P_W-1:0]     p;
    logic [ZOOM_W-1:0]  dz;
    logic [RCP_W-1:0]   rcp;
    logic [FOCUS_W-1:0] f0;
    logic               hold;
  } zfci_prod_t;

  typedef struct packed {
    logic               valid;
    logic [P_W-1:0]     qe;
    logic [P_W-1:0]     p;
    logic [ZOOM_W-1:0]  dz;
    logic [FOCUS_W-1:0] f0;
    logic               hold;
  } zfci_est_t;

  zfci_prod_t                 s3_r;
  zfci_prod_t                 s3_nxt;
  zfci_est_t                  s4_r;
  zfci_est_t                  s4_nxt;
  zfci_quo_t                  quo_r;
  zfci_quo_t                  quo_nxt;
  logic [P_W+RCP_W-1:0]       prod;
  logic [P_W+ZOOM_W-1:0]      chk;

  // stage 3: offset times focus span
  always_comb begin
    s3_nxt.valid = seg.valid;
    s3_nxt.p     = P_W'(seg.off) * P_W'(seg.df);
    s3_nxt.dz    = seg.dz;
    s3_nxt.rcp   = seg.rcp;
    s3_nxt.f0    = seg.f0;
    s3_nxt.hold  = seg.hold;
  end

  // stage 4: quotient estimate, exact or one too high
  always_comb begin
    prod         = (P_W+RCP_W)'(s3_r.p) * (P_W+RCP_W)'(s3_r.rcp);
    s4_nxt.valid = s3_r.valid;
    s4_nxt.qe    = prod[RCP_SH +: P_W];
    s4_nxt.p     = s3_r.p;
    s4_nxt.dz    = s3_r.dz;
    s4_nxt.f0    = s3_r.f0;
    s4_nxt.hold  = s3_r.hold;
  end

  // stage 5: back off by one when the estimate overshoots
  always_comb begin
    chk           = (P_W+ZOOM_W)'(s4_r.qe) * (P_W+ZOOM_W)'(s4_r.dz);
    quo_nxt.valid = s4_r.valid;
    quo_nxt.f0    = s4_r.f0;
    if (s4_r.hold) begin
      quo_nxt.q = '0;
    end else if (chk > (P_W+ZOOM_W)'(s4_r.p)) begin
      quo_nxt.q = s4_r.qe - P_W'(1);
    end else begin
      quo_nxt.q = s4_r.qe;
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.valid  <= 1'b0;
      s4_r.valid  <= 1'b0;
      quo_r.valid <= 1'b0;
    end else if (en) begin
      s3_r  <= s3_nxt;
      s4_r  <= s4_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

FILE: hdl/zoom_focus_curve_interpolator.sv
// zoom_focus_curve_interpolator: top level, maps a zoom position to a focus target.
// Depends on zfci_pkg, zfci_if, zfci_search and zfci_divide.
//
//   channel   dir   handshake                 payload
//   in_ch     in    in_ch.valid/in_ch.ready   zoom_step  [11:0]
//   out_ch    out   out_ch.valid/out_ch.ready focus_step [12:0]
//
// Six register stages: search, segment fetch, multiply, reciprocal divide,
// correction, add and saturate. One request is taken every cycle unless the
// output stalls. All stages advance together and hold when the output
// register is full and not taken. Synchronous active-low reset clears the
// valid bits only.
module zoom_focus_curve_interpolator import zfci_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  zfci_in_if.sink           in_ch,
  zfci_out_if.source        out_ch
);

  logic                 en;
  zfci_seg_t            seg;
  zfci_quo_t            quo;
  logic [P_W:0]         sum;
  logic [FOCUS_W-1:0]   focus_nxt;
  logic                 out_valid_r;
  logic [FOCUS_W-1:0]   focus_r;

  // pipeline advances unless the output holds an untaken result
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  zfci_search u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .zoom_step (in_ch.zoom_step),
    .seg       (seg)
  );

  zfci_divide u_divide (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .seg   (seg),
    .quo   (quo)
  );

  // base focus plus quotient, saturated
  always_comb begin
    sum = (P_W+1)'(quo.f0) + (P_W+1)'(quo.q);
    if (sum > (P_W+1)'(FOCUS_MAX)) begin
      focus_nxt = FOCUS_W'(FOCUS_MAX);
    end else begin
      focus_nxt = FOCUS_W'(sum);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= quo.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      focus_r <= focus_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.focus_step = focus_r;

endmodule

FILE: hdl/zfci_checker.sv
// zfci_checker: port-level assertions for the interpolator, bound to the top level.
// Depends on zfci_pkg; watches the channel signals of zoom_focus_curve_interpolator.
module zfci_checker import zfci_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FOCUS_W-1:0] out_focus_step
);

  logic       in_acc;
  logic       out_acc;
  logic [3:0] cnt_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // requests in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + 4'(in_acc) - 4'(out_acc);
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_focus_step))
    else $error("result changed while stalled");

  // input taken exactly when the output can move
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output state");

  // no result without a pending request
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> cnt_r != 4'd0)
    else $error("result without request");

  // in-flight count bounded by pipeline depth
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 4'(PIPE_DEPTH))
    else $error("too many requests in flight");

  // reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind zoom_focus_curve_interpolator zfci_checker u_zfci_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_focus_step (out_ch.focus_step)
);
